// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros shared by the decoder RTL.
// Needs nothing else; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ON(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  `ASSERT_ON(label, clk, rstn, !(cond), msg)

`endif

// ===== rtl/core/dsm_pkg.sv =====
// Shared types, codes and constants of the serial frame decoder.
// No dependencies; used by every module of the block except dsm_fifo.
`timescale 1ns / 1ps
`default_nettype none

package dsm_pkg;

  // Line event codes
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_GAP     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_LOST   = 2'd2;

  // Accepted mode bytes
  localparam logic [7:0] MODE_1024_A = 8'h01;
  localparam logic [7:0] MODE_2048_A = 8'h12;
  localparam logic [7:0] MODE_2048_B = 8'ha2;
  localparam logic [7:0] MODE_2048_C = 8'hb2;

  localparam int FRAME_BYTES  = 16;
  localparam int CNT_W        = $clog2(FRAME_BYTES);
  localparam int FRAME_WORDS  = FRAME_BYTES / 2;
  localparam int WIDX_W       = $clog2(FRAME_WORDS);
  localparam int NUM_CHANNELS = 16;
  localparam int JOB_DEPTH    = 2;

  localparam logic [3:0] FAIL_MAX   = 4'hf;
  localparam logic [3:0] FAIL_LIMIT_RST = 4'd3;
  localparam logic [7:0] ID_UNMAPPED = 8'hff;

  // value = 1000 * (v + 1025) / 1366; the divide is a multiply by
  // ceil(2^32 / 1366), exact for every product below 2^32 / 342.
  localparam logic [11:0] SCALE_OFS   = 12'd1025;
  localparam logic [21:0] SCALE_MUL   = 22'd1000;
  localparam logic [21:0] SCALE_RECIP = 22'd3144193;

  localparam logic [7:0] ID_REMAP [16] = '{
    8'd2, 8'd0, 8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
    ID_UNMAPPED, ID_UNMAPPED, ID_UNMAPPED, ID_UNMAPPED, ID_UNMAPPED, ID_UNMAPPED
  };

  typedef enum logic [1:0] {
    PH_WAIT_GAP,
    PH_COLLECT,
    PH_AFTER,
    PH_HALT
  } phase_e;

  typedef enum logic {
    JOB_DECODE,
    JOB_LOST
  } job_e;

  typedef struct packed {
    job_e op;
    logic mode10;   // 10-bit values, doubled
  } dsm_job_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } dsm_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [11:0] value;
    logic        last;
  } dsm_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsm_fifo.sv =====
// Small first-word-fall-through queue for decode/lost jobs.
// Standalone; no package use.
`timescale 1ns / 1ps
`default_nettype none

module dsm_fifo #(
  parameter int Width = 2,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsm_front.sv =====
// Front end: line event FSM, frame byte store, failure counting.
// Uses dsm_pkg; pushes jobs into dsm_fifo, serves word reads to dsm_back.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dsm_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [3:0]                 cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire dsm_pkg::dsm_in_t           in_data_i,
  output logic                            push_o,
  output dsm_pkg::dsm_job_t               job_o,
  input  wire logic                       q_full_i,
  input  wire logic                       frame_done_i,
  input  wire logic [dsm_pkg::WIDX_W-1:0] rd_idx_i,
  output logic [15:0]                     rd_word_o
);

  dsm_pkg::phase_e phase_q, phase_d;
  logic [dsm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]  fail_q, fail_d, fail_inc;
  logic [3:0]  fail_limit_q;
  logic        lock_q, lock_d;
  logic        acc, wr_en, mode_ok;
  logic [7:0]  mode;
  logic [15:0] word_q [dsm_pkg::FRAME_WORDS];

  assign in_ready_o = !lock_q && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign mode       = word_q[0][7:0];
  assign rd_word_o  = word_q[rd_idx_i];
  assign fail_inc   = (fail_q == dsm_pkg::FAIL_MAX) ? fail_q : fail_q + 4'd1;

  always_comb begin
    mode_ok = mode inside {dsm_pkg::MODE_1024_A, dsm_pkg::MODE_2048_A,
                           dsm_pkg::MODE_2048_B, dsm_pkg::MODE_2048_C};
  end

  always_comb begin
    logic fail;
    fail       = 1'b0;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    fail_d     = fail_q;
    lock_d     = lock_q && !frame_done_i;
    wr_en      = 1'b0;
    push_o     = 1'b0;
    job_o.op     = dsm_pkg::JOB_DECODE;
    job_o.mode10 = (mode == dsm_pkg::MODE_1024_A);
    if (acc && in_data_i.cmd != dsm_pkg::CMD_NONE) begin
      case (phase_q)
        dsm_pkg::PH_WAIT_GAP: begin
          if (in_data_i.cmd == dsm_pkg::CMD_GAP) begin
            phase_d = dsm_pkg::PH_COLLECT;
            cnt_d   = '0;
          end else if (in_data_i.cmd == dsm_pkg::CMD_TIMEOUT) begin
            fail = 1'b1;
          end
        end
        dsm_pkg::PH_COLLECT: begin
          if (in_data_i.cmd == dsm_pkg::CMD_BYTE) begin
            wr_en = 1'b1;
            if (cnt_q == dsm_pkg::CNT_W'(dsm_pkg::FRAME_BYTES - 1)) begin
              cnt_d = '0;
              if (mode_ok) begin
                push_o  = 1'b1;
                lock_d  = 1'b1;
                phase_d = dsm_pkg::PH_AFTER;
              end else begin
                fail = 1'b1;
              end
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else if (in_data_i.cmd == dsm_pkg::CMD_TIMEOUT) begin
            fail = 1'b1;
          end
        end
        dsm_pkg::PH_AFTER: begin
          if (in_data_i.cmd == dsm_pkg::CMD_GAP) begin
            fail_d  = '0;
            cnt_d   = '0;
            phase_d = dsm_pkg::PH_COLLECT;
          end else begin
            fail = 1'b1;
          end
        end
        default: ;  // halted: ignore everything
      endcase
    end
    if (fail) begin
      fail_d = fail_inc;
      if (fail_inc >= fail_limit_q) begin
        phase_d  = dsm_pkg::PH_HALT;
        push_o   = 1'b1;
        job_o.op = dsm_pkg::JOB_LOST;
      end else begin
        phase_d = dsm_pkg::PH_WAIT_GAP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= dsm_pkg::PH_WAIT_GAP;
      cnt_q        <= '0;
      fail_q       <= '0;
      lock_q       <= 1'b0;
      fail_limit_q <= dsm_pkg::FAIL_LIMIT_RST;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
      lock_q  <= lock_d;
      if (cfg_we_i) begin
        fail_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Frame store: even bytes fill the high half of a word, odd bytes the low
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (cnt_q[0]) begin
        word_q[cnt_q[dsm_pkg::CNT_W-1:1]][7:0] <= in_data_i.data_byte;
      end else begin
        word_q[cnt_q[dsm_pkg::CNT_W-1:1]][15:8] <= in_data_i.data_byte;
      end
    end
  end

  // A decode job is only queued for a good frame, and nothing is accepted
  // until the back end has read it out, so the phase sits in after-frame.
  `ASSERT_ON(a_lock_after, clk_i, rst_ni, lock_q |-> phase_q == dsm_pkg::PH_AFTER, "stray lock")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_o && q_full_i, "push into full queue")

endmodule

`default_nettype wire

// ===== rtl/core/dsm_back.sv =====
// Back end: walks a queued job, decodes and scales channel words,
// and drives the registered result port. Uses dsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dsm_back #(
  parameter int NumChannels = dsm_pkg::NUM_CHANNELS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dsm_pkg::dsm_job_t          job_i,
  input  wire logic                       q_empty_i,
  output logic                            pop_o,
  output logic                            frame_done_o,
  output logic [dsm_pkg::WIDX_W-1:0]      rd_idx_o,
  input  wire logic [15:0]                rd_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output dsm_pkg::dsm_out_t               out_data_o
);

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [21:0] prod;
    logic        last;
  } stage_t;

  localparam logic [dsm_pkg::WIDX_W-1:0] REPORT_STEP =
    dsm_pkg::WIDX_W'(dsm_pkg::FRAME_WORDS - 1);

  stage_t s1_q, s1_d;
  logic [dsm_pkg::WIDX_W-1:0] step_q, step_d;
  logic        out_vld_q;
  dsm_pkg::dsm_out_t out_q;
  logic        en;
  logic [7:0]  hi, lo, ch8;
  logic [3:0]  id;
  logic [10:0] v;
  logic [11:0] sum;
  logic [43:0] quot;

  assign en          = !out_vld_q || out_ready_i;
  assign rd_idx_o    = step_q + 1'b1;
  assign hi          = rd_word_i[15:8];
  assign lo          = rd_word_i[7:0];
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (job_i.mode10) begin
      v  = {hi[1:0], lo, 1'b0};
      id = hi[5:2];
    end else begin
      v  = {hi[2:0], lo};
      id = hi[6:3];
    end
    ch8 = dsm_pkg::ID_REMAP[id];
    sum = {1'b0, v} + dsm_pkg::SCALE_OFS;
  end

  always_comb begin
    s1_d         = '0;
    step_d       = step_q;
    pop_o        = 1'b0;
    frame_done_o = 1'b0;
    if (en && !q_empty_i) begin
      case (job_i.op)
        dsm_pkg::JOB_LOST: begin
          s1_d.vld  = 1'b1;
          s1_d.kind = dsm_pkg::KIND_LOST;
          s1_d.last = 1'b1;
          pop_o     = 1'b1;
        end
        dsm_pkg::JOB_DECODE: begin
          if (step_q == REPORT_STEP) begin
            s1_d.vld     = 1'b1;
            s1_d.kind    = dsm_pkg::KIND_REPORT;
            s1_d.last    = 1'b1;
            pop_o        = 1'b1;
            frame_done_o = 1'b1;
            step_d       = '0;
          end else begin
            s1_d.vld     = (ch8 < 8'(NumChannels));
            s1_d.kind    = dsm_pkg::KIND_UPDATE;
            s1_d.channel = ch8[3:0];
            s1_d.prod    = 22'({10'd0, sum} * dsm_pkg::SCALE_MUL);
            step_d       = step_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Divide by 1366 as a reciprocal multiply; top bits hold the quotient
  assign quot = {22'd0, s1_q.prod} * {22'd0, dsm_pkg::SCALE_RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
      step_q    <= '0;
    end else begin
      step_q <= step_d;
      if (en) begin
        s1_q          <= s1_d;
        out_vld_q     <= s1_q.vld;
        out_q.kind    <= s1_q.kind;
        out_q.channel <= s1_q.channel;
        out_q.value   <= quot[43:32];
        out_q.last    <= s1_q.last;
      end
    end
  end

  `ASSERT_NEVER(a_done_empty, clk_i, rst_ni, frame_done_o && q_empty_i, "frame done with no job")
  `ASSERT_ON(a_lost_last, clk_i, rst_ni, (out_vld_q && out_q.kind == dsm_pkg::KIND_LOST) |-> out_q.last, "link lost not last")

endmodule

`default_nettype wire

// ===== rtl/core/dsm_serial_frame_decoder.sv =====
// Top level of the serial frame decoder: front end, job queue, back end.
// Depends on dsm_pkg, dsm_front, dsm_fifo and dsm_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | sink      | in_valid_i / in_ready_o  | dsm_in_t  (cmd, data_byte)
//  out     | source    | out_valid_o / out_ready_i| dsm_out_t (kind, channel,
//          |           |                        |   value, last)
//  cfg     | sink      | cfg_we_i (no wait)     | cfg_wdata_i = fail limit
//
// The 16th byte of a good frame queues a decode job; the back end then walks
// seven channel words plus the report, and results leave through the two-stage
// scaling pipe. in_ready_o stays low from that byte until the back end has
// read the whole frame store. Reset clears all control state; the frame store
// is not reset. A stalled output freezes the back end only; the front end keeps
// taking transactions until a good frame completes, then waits for the back end
// to read it out.
`timescale 1ns / 1ps
`default_nettype none

module dsm_serial_frame_decoder #(
  parameter int NumChannels = dsm_pkg::NUM_CHANNELS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [3:0]        cfg_wdata_i,
  // line events
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dsm_pkg::dsm_in_t  in_data_i,
  // results
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dsm_pkg::dsm_out_t      out_data_o
);

  localparam int JobW = $bits(dsm_pkg::dsm_job_t);

  dsm_pkg::dsm_job_t         push_job, head_job;
  logic [JobW-1:0]           head_bits;
  logic                      push, pop, q_empty, q_full, frame_done;
  logic [dsm_pkg::WIDX_W-1:0] rd_idx;
  logic [15:0]               rd_word;

  // Front end: phase tracking, frame capture, mode check, failure count
  dsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .job_o        (push_job),
    .q_full_i     (q_full),
    .frame_done_i (frame_done),
    .rd_idx_i     (rd_idx),
    .rd_word_o    (rd_word)
  );

  // Job queue decouples event handling from result generation
  dsm_fifo #(
    .Width (JobW),
    .Depth (dsm_pkg::JOB_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_bits),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign head_job = dsm_pkg::dsm_job_t'(head_bits);

  // Back end: word decode, id remap, scaling, result register
  dsm_back #(
    .NumChannels (NumChannels)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .frame_done_o (frame_done),
    .rd_idx_o     (rd_idx),
    .rd_word_i    (rd_word),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
